### src/sha1md_pkg.sv
// Shared types, constants and round functions of the SHA-1 digest block.
`default_nettype none
package sha1md_pkg;

   localparam int LENGTH_COUNTER_BITS = 64;
   localparam int BYTE_COUNT_BITS     = LENGTH_COUNTER_BITS - 3;
   localparam int DIGEST_WORDS        = 5;
   localparam int BLOCK_WORDS         = 16;
   localparam int SLOT_BITS           = $clog2(BLOCK_WORDS);
   localparam int ROUNDS              = 80;

   typedef logic [31:0] word_type;

   localparam word_type INIT_H0 = 32'h67452301;
   localparam word_type INIT_H1 = 32'hEFCDAB89;
   localparam word_type INIT_H2 = 32'h98BADCFE;
   localparam word_type INIT_H3 = 32'h10325476;
   localparam word_type INIT_H4 = 32'hC3D2E1F0;

   localparam word_type ROUND_K0 = 32'h5A827999;
   localparam word_type ROUND_K1 = 32'h6ED9EBA1;
   localparam word_type ROUND_K2 = 32'h8F1BBCDC;
   localparam word_type ROUND_K3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_MARK_BYTE = 8'h80;
   localparam logic [5:0] LENGTH_START  = 6'd56;
   localparam logic [5:0] BLOCK_LAST    = 6'd63;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PAD,
      ST_PRIME,
      ST_ROUND,
      ST_SCHED,
      ST_FINISH,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PAD_MARK,
      PAD_ZERO,
      PAD_LEN
   } pad_type;

   typedef struct packed {
      logic       load_vars;
      logic       round_en;
      logic [6:0] round_idx;
      logic       finish;
      logic       chain_init;
      logic       chain_shift;
   } core_ctl_type;

   function automatic word_type rotl1(word_type x);
      return {x[30:0], x[31]};
   endfunction

   function automatic word_type rotl5(word_type x);
      return {x[26:0], x[31:27]};
   endfunction

   function automatic word_type rotl30(word_type x);
      return {x[1:0], x[31:2]};
   endfunction

   function automatic word_type round_f(logic [6:0] t, word_type b, word_type c, word_type d);
      word_type f;
      if (t < 7'd20) begin
         f = (b & c) | (~b & d);
      end else if (t < 7'd40) begin
         f = b ^ c ^ d;
      end else if (t < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

   function automatic word_type round_k(logic [6:0] t);
      word_type k;
      if (t < 7'd20) begin
         k = ROUND_K0;
      end else if (t < 7'd40) begin
         k = ROUND_K1;
      end else if (t < 7'd60) begin
         k = ROUND_K2;
      end else begin
         k = ROUND_K3;
      end
      return k;
   endfunction

endpackage
`default_nettype wire

### src/sha1md_ram.sv
// Generic RAM: one write port, two registered read ports.
`default_nettype none
module sha1md_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr_a,
   output logic      [WIDTH-1:0] rd_data_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

### src/sha1md_core.sv
// SHA-1 round datapath: working variables a..e and the chaining words.
`default_nettype none
module sha1md_core (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sha1md_pkg::core_ctl_type  ctl,
   input  wire sha1md_pkg::word_type      sched_word,
   output sha1md_pkg::word_type           chain_head
);

   sha1md_pkg::word_type var_ff   [sha1md_pkg::DIGEST_WORDS];
   sha1md_pkg::word_type chain_ff [sha1md_pkg::DIGEST_WORDS];
   sha1md_pkg::word_type temp_in;

   always_comb begin
      temp_in = sha1md_pkg::rotl5(var_ff[0])
              + sha1md_pkg::round_f(ctl.round_idx, var_ff[1], var_ff[2], var_ff[3])
              + var_ff[4] + sched_word + sha1md_pkg::round_k(ctl.round_idx);
   end

   // working variables carry no reset; they are loaded before every block
   always_ff @(posedge clock) begin
      if (ctl.load_vars) begin
         for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
            var_ff[i] <= chain_ff[i];
         end
      end else if (ctl.round_en) begin
         var_ff[0] <= temp_in;
         var_ff[1] <= var_ff[0];
         var_ff[2] <= sha1md_pkg::rotl30(var_ff[1]);
         var_ff[3] <= var_ff[2];
         var_ff[4] <= var_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.chain_init) begin
         chain_ff[0] <= sha1md_pkg::INIT_H0;
         chain_ff[1] <= sha1md_pkg::INIT_H1;
         chain_ff[2] <= sha1md_pkg::INIT_H2;
         chain_ff[3] <= sha1md_pkg::INIT_H3;
         chain_ff[4] <= sha1md_pkg::INIT_H4;
      end else if (ctl.finish) begin
         for (int i = 0; i < sha1md_pkg::DIGEST_WORDS; i++) begin
            chain_ff[i] <= chain_ff[i] + var_ff[i];
         end
      end else if (ctl.chain_shift) begin
         for (int i = 0; i < sha1md_pkg::DIGEST_WORDS - 1; i++) begin
            chain_ff[i] <= chain_ff[i + 1];
         end
         chain_ff[sha1md_pkg::DIGEST_WORDS - 1] <= chain_ff[0];
      end
   end

   assign chain_head = chain_ff[0];

endmodule
`default_nettype wire

### src/sha1_message_digest.sv
// SHA-1 message digest top level: byte loader, pad generator, round sequencer, output.
//
// Message bytes come in one item per cycle while the block is loading and are packed
// big-endian into a 16-word schedule RAM. When the 64th byte of a block lands, input
// stalls and the compression runs: ST_PRIME primes the RAM read and loads the working
// variables, ST_ROUND alone serves rounds 0-15, and each of rounds 16-79 passes through
// ST_SCHED and then ST_ROUND (the four schedule taps are fetched through the RAM's two
// read ports, two in ST_ROUND and two in ST_SCHED); ST_FINISH then folds the working
// variables into the chaining words. An item with is_last (after its own byte, if
// byte_valid is set) starts padding: the 0x80 mark, zeros and the 64-bit big-endian
// bit length are generated internally, one byte per cycle, filling the rest of the
// current block and one more block if needed, each compressed as above. The digest
// then leaves as five items, h0 first, through an output register; the next message
// may start as soon as the last word is loaded into that register. The bit length
// counter is LENGTH_COUNTER_BITS wide and wraps.
`default_nettype none
module sha1_message_digest (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sha1md_pkg::req_type  req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output sha1md_pkg::rsp_type       rsp_data
);

   localparam int SB = sha1md_pkg::SLOT_BITS;

   // sequencer state
   sha1md_pkg::state_type state_ff, state_in;
   sha1md_pkg::pad_type   pad_ff, pad_in;
   logic [5:0]  pos_ff, pos_in;          // byte position in current block
   logic [23:0] asm_ff, asm_in;          // first three bytes of the word being packed
   logic [sha1md_pkg::BYTE_COUNT_BITS-1:0] cnt_ff, cnt_in;   // message bytes, wraps
   logic        closing_ff, closing_in;  // padding in progress
   logic        due_ff, due_in;          // last padded block under compression
   logic [6:0]  round_ff, round_in;
   sha1md_pkg::word_type x1_ff, x1_in;   // first half of the schedule XOR
   logic [2:0]  out_idx_ff, out_idx_in;
   logic        rsp_valid_ff, rsp_valid_in;
   sha1md_pkg::rsp_type rsp_ff, rsp_in;

   // byte push path
   logic        push_en;
   logic [7:0]  push_byte;
   logic [7:0]  pad_byte;
   logic [63:0] len_bits;
   logic        block_full;
   logic        accept;

   // schedule RAM
   logic                 ram_wr_en;
   logic [SB-1:0]        ram_wr_addr;
   sha1md_pkg::word_type ram_wr_data;
   logic [SB-1:0]        ram_rd_addr_a;
   logic [SB-1:0]        ram_rd_addr_b;
   sha1md_pkg::word_type ram_rd_data_a;
   sha1md_pkg::word_type ram_rd_data_b;

   sha1md_pkg::core_ctl_type ctl;
   sha1md_pkg::word_type     sched_word;
   sha1md_pkg::word_type     chain_head;
   logic [6:0]               round_next;

   assign len_bits   = 64'({cnt_ff, 3'b000});
   assign round_next = round_ff + 7'd1;

   always_comb begin
      case (pad_ff)
         sha1md_pkg::PAD_MARK: pad_byte = sha1md_pkg::PAD_MARK_BYTE;
         sha1md_pkg::PAD_LEN:  pad_byte = len_bits[{3'd7 - pos_ff[2:0], 3'b000} +: 8];
         default:              pad_byte = 8'h00;
      endcase
   end

   // schedule word for the current round: stored word, or expanded in place
   assign sched_word = (round_ff < 7'(sha1md_pkg::BLOCK_WORDS)) ? ram_rd_data_a :
                       sha1md_pkg::rotl1(x1_ff ^ ram_rd_data_a ^ ram_rd_data_b);

   assign block_full = push_en && (pos_ff == sha1md_pkg::BLOCK_LAST);

   always_comb begin
      state_in     = state_ff;
      pad_in       = pad_ff;
      pos_in       = pos_ff;
      asm_in       = asm_ff;
      cnt_in       = cnt_ff;
      closing_in   = closing_ff;
      due_in       = due_ff;
      round_in     = round_ff;
      x1_in        = x1_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      req_ready     = 1'b0;
      accept        = 1'b0;
      push_en       = 1'b0;
      push_byte     = pad_byte;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = round_ff[SB-1:0];
      ram_wr_data   = sched_word;
      ram_rd_addr_a = round_ff[SB-1:0];
      ram_rd_addr_b = round_ff[SB-1:0];

      ctl             = '0;
      ctl.round_idx   = round_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sha1md_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            accept    = req_valid;
            push_en   = accept && req_data.byte_valid;
            push_byte = req_data.data_byte;
            if (push_en) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (accept && req_data.is_last) begin
               closing_in = 1'b1;
               pad_in     = sha1md_pkg::PAD_MARK;
            end
            if (block_full) begin
               state_in = sha1md_pkg::ST_PRIME;
            end else if (accept && req_data.is_last) begin
               state_in = sha1md_pkg::ST_PAD;
            end
         end

         sha1md_pkg::ST_PAD: begin
            push_en = 1'b1;
            if (block_full) begin
               state_in = sha1md_pkg::ST_PRIME;
               if (pad_ff == sha1md_pkg::PAD_LEN) begin
                  due_in = 1'b1;
               end
            end
         end

         sha1md_pkg::ST_PRIME: begin
            ctl.load_vars = 1'b1;
            round_in      = 7'd0;
            ram_rd_addr_a = '0;
            state_in      = sha1md_pkg::ST_ROUND;
         end

         sha1md_pkg::ST_ROUND: begin
            ctl.round_en = 1'b1;
            if (round_ff >= 7'(sha1md_pkg::BLOCK_WORDS)) begin
               ram_wr_en = 1'b1;
            end
            // fetch for the next round: its own slot, or the first two schedule taps
            ram_rd_addr_a = round_next[SB-1:0];
            ram_rd_addr_b = round_next[SB-1:0] + SB'(2);
            round_in      = round_next;
            if (round_ff == 7'(sha1md_pkg::ROUNDS - 1)) begin
               state_in = sha1md_pkg::ST_FINISH;
            end else if (round_next >= 7'(sha1md_pkg::BLOCK_WORDS)) begin
               state_in = sha1md_pkg::ST_SCHED;
            end
         end

         sha1md_pkg::ST_SCHED: begin
            x1_in         = ram_rd_data_a ^ ram_rd_data_b;
            ram_rd_addr_a = round_ff[SB-1:0] + SB'(8);
            ram_rd_addr_b = round_ff[SB-1:0] + SB'(13);
            state_in      = sha1md_pkg::ST_ROUND;
         end

         sha1md_pkg::ST_FINISH: begin
            ctl.finish = 1'b1;
            round_in   = 7'd0;
            if (due_ff) begin
               state_in   = sha1md_pkg::ST_OUT;
               out_idx_in = 3'd0;
            end else if (closing_ff) begin
               state_in = sha1md_pkg::ST_PAD;
            end else begin
               state_in = sha1md_pkg::ST_LOAD;
            end
         end

         sha1md_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.digest_word = chain_head;
               rsp_in.word_index  = out_idx_ff;
               rsp_in.last_word   = (out_idx_ff == 3'(sha1md_pkg::DIGEST_WORDS - 1));
               out_idx_in         = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'(sha1md_pkg::DIGEST_WORDS - 1)) begin
                  // message done: back to the reset state
                  ctl.chain_init = 1'b1;
                  pos_in         = 6'd0;
                  cnt_in         = '0;
                  pad_in         = sha1md_pkg::PAD_MARK;
                  closing_in     = 1'b0;
                  due_in         = 1'b0;
                  state_in       = sha1md_pkg::ST_LOAD;
               end else begin
                  ctl.chain_shift = 1'b1;
               end
            end
         end

         default: begin
            state_in = sha1md_pkg::ST_LOAD;
         end
      endcase

      // shared byte packing: every fourth byte completes a word into the RAM
      if (push_en) begin
         asm_in = {asm_ff[15:0], push_byte};
         pos_in = pos_ff + 6'd1;
         if (pos_ff[1:0] == 2'b11) begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[5:2];
            ram_wr_data = {asm_ff, push_byte};
         end
         if (state_ff == sha1md_pkg::ST_PAD) begin
            if (pad_ff != sha1md_pkg::PAD_LEN) begin
               if (pos_ff + 6'd1 == sha1md_pkg::LENGTH_START) begin
                  pad_in = sha1md_pkg::PAD_LEN;
               end else begin
                  pad_in = sha1md_pkg::PAD_ZERO;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha1md_pkg::ST_LOAD;
         pad_ff       <= sha1md_pkg::PAD_MARK;
         pos_ff       <= 6'd0;
         cnt_ff       <= '0;
         closing_ff   <= 1'b0;
         due_ff       <= 1'b0;
         round_ff     <= 7'd0;
         out_idx_ff   <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pad_ff       <= pad_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         closing_ff   <= closing_in;
         due_ff       <= due_in;
         round_ff     <= round_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      asm_ff <= asm_in;
      x1_ff  <= x1_in;
      rsp_ff <= rsp_in;
   end

   sha1md_ram #(
      .WIDTH (32),
      .DEPTH (sha1md_pkg::BLOCK_WORDS)
   ) u_sched_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_addr_a (ram_rd_addr_a),
      .rd_data_a (ram_rd_data_a),
      .rd_addr_b (ram_rd_addr_b),
      .rd_data_b (ram_rd_data_b)
   );

   sha1md_core u_core (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sched_word (sched_word),
      .chain_head (chain_head)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### src/sha1md_checker.sv
// Port-level checker for the SHA-1 digest block, bound to the top level.
`default_nettype none
module sha1md_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire sha1md_pkg::req_type  req_data,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire sha1md_pkg::rsp_type  rsp_data
);

   // a stalled input item holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("input item changed while stalled");

   // a stalled digest item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("digest item changed while stalled");

   // last_word marks exactly the h4 word
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == 3'd4)))
      else $error("last_word and word_index disagree");

   // words follow one another in order without gaps
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_word |=>
         rsp_valid && (rsp_data.word_index == 3'($past(rsp_data.word_index) + 3'd1)))
      else $error("digest words out of order");

   // no new message byte while the digest is still going out
   a_no_input_mid_digest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_word |-> !req_ready)
      else $error("input taken during digest output");

endmodule

bind sha1_message_digest sha1md_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire

### bench/sha1_message_digest_test.sv
// Self-checking bench for the streaming SHA-1 digest: random messages, random idling.
`default_nettype none
module sha1_message_digest_test;

   // Clock and the single reset at the start of the run.
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Byte channel into the block and digest channel out of it.
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   sha1md_pkg::req_type  req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   sha1md_pkg::rsp_type  rsp_data;

   sha1_message_digest DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Items waiting for the driver, and digest words the block still owes us.
   sha1md_pkg::req_type pending_items[$];
   sha1md_pkg::rsp_type expected_words[$];

   int error_count   = 0;
   int message_count = 0;
   int item_count    = 0;   // items that carry a byte or an end; idle items excluded
   int cycle_count   = 0;

   // Idling is switched off over one long window so the block also sees back-to-back
   // traffic on both channels.
   localparam int CALM_FIRST = 600;
   localparam int CALM_LAST  = 2000;

   // ---------------------------------------------------------------------------
   // Digest predictor: its own copy of the hash state, updated on each accepted item.
   // ---------------------------------------------------------------------------
   sha1md_pkg::word_type digest_chain[sha1md_pkg::DIGEST_WORDS];
   sha1md_pkg::word_type schedule_words[sha1md_pkg::BLOCK_WORDS];
   int          block_fill;     // bytes already packed into the current block
   logic [63:0] message_bits;   // running message length in bits

   function automatic void restart_digest();
      digest_chain   = '{sha1md_pkg::INIT_H0, sha1md_pkg::INIT_H1, sha1md_pkg::INIT_H2,
                         sha1md_pkg::INIT_H3, sha1md_pkg::INIT_H4};
      schedule_words = '{default: '0};
      block_fill     = 0;
      message_bits   = '0;
   endfunction

   // Packs one byte big-endian; the 64th byte of a block runs the 80 rounds.
   function automatic void absorb_byte(logic [7:0] value);
      sha1md_pkg::word_type a, b, c, d, e, w, f, k, t;
      int pos, slot;
      pos = block_fill;
      schedule_words[pos / 4] |= sha1md_pkg::word_type'(value) << (24 - 8 * (pos % 4));
      block_fill = (pos + 1) % 64;
      if (block_fill == 0) begin
         a = digest_chain[0];
         b = digest_chain[1];
         c = digest_chain[2];
         d = digest_chain[3];
         e = digest_chain[4];
         for (int r = 0; r < sha1md_pkg::ROUNDS; r++) begin
            slot = r % 16;
            // schedule is expanded in place over a 16-word window
            if (r >= 16) begin
               w = schedule_words[(slot + 13) % 16] ^ schedule_words[(slot + 8) % 16]
                 ^ schedule_words[(slot + 2) % 16] ^ schedule_words[slot];
               schedule_words[slot] = {w[30:0], w[31]};
            end
            w = schedule_words[slot];
            if (r < 20) begin
               f = (b & c) | (~b & d);
               k = sha1md_pkg::ROUND_K0;
            end else if (r < 40) begin
               f = b ^ c ^ d;
               k = sha1md_pkg::ROUND_K1;
            end else if (r < 60) begin
               f = (b & c) | (b & d) | (c & d);
               k = sha1md_pkg::ROUND_K2;
            end else begin
               f = b ^ c ^ d;
               k = sha1md_pkg::ROUND_K3;
            end
            t = {a[26:0], a[31:27]} + f + e + w + k;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
         end
         digest_chain[0] += a;
         digest_chain[1] += b;
         digest_chain[2] += c;
         digest_chain[3] += d;
         digest_chain[4] += e;
         schedule_words = '{default: '0};
      end
   endfunction

   // Byte first (if any), then on the end mark: pad, length, five digest words.
   function automatic void predict_item(sha1md_pkg::req_type it);
      logic [63:0]         length_field;
      sha1md_pkg::rsp_type word_out;
      if (it.byte_valid) begin
         absorb_byte(it.data_byte);
         message_bits += 64'd8;
      end
      if (it.is_last) begin
         length_field = message_bits;
         absorb_byte(sha1md_pkg::PAD_MARK_BYTE);
         while (block_fill != sha1md_pkg::LENGTH_START) absorb_byte(8'h00);
         for (int n = 0; n < 8; n++) absorb_byte(length_field[63 - 8 * n -: 8]);
         for (int n = 0; n < sha1md_pkg::DIGEST_WORDS; n++) begin
            word_out.digest_word = digest_chain[n];
            word_out.word_index  = 3'(n);
            word_out.last_word   = (n == sha1md_pkg::DIGEST_WORDS - 1);
            expected_words.push_back(word_out);
         end
         restart_digest();
      end
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------------
   task automatic add_item(logic [7:0] data, logic has_byte, logic ends);
      sha1md_pkg::req_type it;
      it.data_byte  = data;
      it.byte_valid = has_byte;
      it.is_last    = ends;
      pending_items.push_back(it);
      if (has_byte || ends) item_count++;
   endtask

   // A message of 'length' random bytes. With 'together' set the end mark rides on
   // the final byte; otherwise a separate item with no byte closes the message.
   // Idle items (no byte, no end) are sprinkled in between.
   task automatic add_message(int length, bit together);
      for (int i = 0; i < length; i++) begin
         if ($urandom_range(99) < 10) add_item(8'($urandom), 1'b0, 1'b0);
         add_item(8'($urandom), 1'b1, together && (i == length - 1));
      end
      if (!together || length == 0) add_item(8'($urandom), 1'b0, 1'b1);
      message_count++;
   endtask

   // ---------------------------------------------------------------------------
   // Driver: offers the next item once the current one is taken, idling at random.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (req_valid && req_ready) begin
            predict_item(req_data);
         end
         // valid is only touched when nothing is held, so a held item never drops
         if (!req_valid || req_ready) begin
            if (pending_items.size() != 0 &&
                ((cycle_count >= CALM_FIRST && cycle_count < CALM_LAST) ||
                 $urandom_range(99) >= 15)) begin
               req_valid <= 1'b1;
               req_data  <= pending_items.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Monitor: random back-pressure on the digest side, every word checked in order.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : watch_digest
      sha1md_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= (cycle_count >= CALM_FIRST && cycle_count < CALM_LAST) ||
                      ($urandom_range(99) >= 15);
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected digest item: word %h index %0d last %b",
                      rsp_data.digest_word, rsp_data.word_index, rsp_data.last_word);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_data.digest_word !== want.digest_word) begin
                  $error("digest_word: expected %h, got %h",
                         want.digest_word, rsp_data.digest_word);
                  error_count++;
               end
               if (rsp_data.word_index !== want.word_index) begin
                  $error("word_index: expected %0d, got %0d",
                         want.word_index, rsp_data.word_index);
                  error_count++;
               end
               if (rsp_data.last_word !== want.last_word) begin
                  $error("last_word: expected %b, got %b",
                         want.last_word, rsp_data.last_word);
                  error_count++;
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      int pick;
      int length;
      restart_digest();

      // Directed: idle item, empty message, "abc" with the end on its last byte,
      // extreme bytes with and without a separate end, an idle item mid-message.
      add_item(8'h5A, 1'b0, 1'b0);
      add_item(8'hA5, 1'b0, 1'b1);
      message_count++;
      add_item(8'h61, 1'b1, 1'b0);
      add_item(8'h62, 1'b1, 1'b0);
      add_item(8'h63, 1'b1, 1'b1);
      message_count++;
      add_item(8'hFF, 1'b1, 1'b0);
      add_item(8'h00, 1'b0, 1'b1);
      message_count++;
      add_item(8'h00, 1'b1, 1'b1);
      message_count++;
      add_item(8'h80, 1'b1, 1'b0);
      add_item(8'hFF, 1'b0, 1'b0);
      add_item(8'h7F, 1'b1, 1'b0);
      add_item(8'h01, 1'b1, 1'b1);
      message_count++;
      add_message(3, 1'b0);

      // Random messages: many short, some mid-size, and a share sitting on the
      // pad boundaries (one vs. two pad blocks, exact block multiples).
      while (item_count < 260 || message_count * sha1md_pkg::DIGEST_WORDS < 60) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            length = $urandom_range(7);
         end else if (pick < 70) begin
            length = $urandom_range(54, 8);
         end else begin
            case ($urandom_range(7))
               0: length = 55;
               1: length = 56;
               2: length = 57;
               3: length = 63;
               4: length = 64;
               5: length = 65;
               6: length = 119;
               default: length = 120;
            endcase
         end
         add_message(length, $urandom_range(1));
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Everything handed over, then every digest word back, then a quiet tail
      // long enough for a two-block pad to show any stray output.
      while (pending_items.size() != 0 || req_valid) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (500) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #7200000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire

### files.f
src/sha1md_pkg.sv
src/sha1md_ram.sv
src/sha1md_core.sv
src/sha1_message_digest.sv
src/sha1md_checker.sv
bench/sha1_message_digest_test.sv
